// ----- hw/rtl/nhpt_pkg.sv -----
package nhpt_pkg;

	// Default sizing of the table and of the hop walk.
	localparam int NODE_COUNT_MAX_DEF = 256;
	localparam int HOP_LIMIT_DEF      = 500;

	// Largest value that the hop_cost field can show.
	localparam int COST_FIELD_MAX = 511;

	// Reset value of the active_nodes register.
	localparam logic [8:0] ACTIVE_NODES_RST = 9'd1;

	// Operation codes of the func field.
	localparam logic [2:0] FUNC_QUERY   = 3'd0;
	localparam logic [2:0] FUNC_ADD     = 3'd1;
	localparam logic [2:0] FUNC_REMOVE  = 3'd2;
	localparam logic [2:0] FUNC_RESOLVE = 3'd3;
	localparam logic [2:0] FUNC_CLEAR   = 3'd4;

	// One request item.
	typedef struct packed {
		logic [2:0] func;
		logic [7:0] from_node;
		logic [7:0] to_node;
	} req_item_t;

	// One response item.
	typedef struct packed {
		logic       reachable;
		logic [8:0] hop_cost;
		logic       capped;
	} rsp_item_t;

endpackage

// ----- hw/rtl/next_hop_path_table.sv -----
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_we               cfg_wdata  (active_nodes, 9 bit)
// req       in         req_valid/req_stall  req        (func, from_node, to_node)
// rsp       out        rsp_valid/rsp_stall  rsp        (reachable, hop_cost, capped)
//
// One request is in work at a time; req_stall is high until its response sits in the
// output register. Add and remove link stream one column or row entry per cycle
// through the table's read port, over the active nodes. A cost query reads one table
// entry per hop; resolve all reads every pair and starts a spread for each direct
// link found; clear table writes every table entry (65536 at 256 nodes). After reset
// the same clearing pass runs over the whole table before the first request. The
// response waits in its register while rsp_stall is high.
module next_hop_path_table
	import nhpt_pkg::*;
#(
	parameter int NODE_COUNT_MAX = NODE_COUNT_MAX_DEF,
	parameter int HOP_LIMIT      = HOP_LIMIT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [8:0] cfg_wdata,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	// Widths that follow from the node count and the hop limit.
	localparam int IDX_W  = $clog2(NODE_COUNT_MAX);
	localparam int CNT_W  = $clog2(NODE_COUNT_MAX + 1);
	localparam int LW     = (CNT_W > 9) ? CNT_W : 9;
	localparam int CW_RAW = $clog2(HOP_LIMIT + 2);
	localparam int CW     = (CW_RAW > 10) ? CW_RAW : 10;
	localparam int AW     = 2 * IDX_W;
	localparam int ENT_W  = IDX_W + 1;
	localparam int DEPTH  = 1 << AW;

	// Sequencer states.
	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_ADD_W  = 4'd2;
	localparam logic [3:0] S_REM_W  = 4'd3;
	localparam logic [3:0] S_SCAN   = 4'd4;
	localparam logic [3:0] S_RES_RD = 4'd5;
	localparam logic [3:0] S_RES_EV = 4'd6;
	localparam logic [3:0] S_Q_EV   = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	// Scan modes.
	localparam logic MODE_SPREAD = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// Control and working registers.
	logic [3:0]       state_q, state_d;
	logic [8:0]       active_q;
	logic [AW-1:0]    clr_q, clr_d;
	logic             clr_op_q, clr_op_d;
	logic [IDX_W-1:0] src_q, src_d;
	logic [IDX_W-1:0] dst_q, dst_d;
	logic             mode_q, mode_d;
	logic             ret_res_q, ret_res_d;
	logic [CNT_W-1:0] i_q, i_d;
	logic             pend_q, pend_d;
	logic [IDX_W-1:0] pidx_q, pidx_d;
	logic [CNT_W-1:0] r_q, r_d;
	logic [CNT_W-1:0] c_q, c_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	rsp_item_t        res_q, res_d;
	rsp_item_t        out_q, out_d;
	logic             out_valid_q, out_valid_d;

	// Table memory and its ports.
	logic [ENT_W-1:0] mem_q [DEPTH];
	logic [ENT_W-1:0] rd_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [ENT_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr;

	// Helper values.
	logic [LW-1:0]    n_ext;
	logic [CNT_W-1:0] n;
	logic             rd_vld;
	logic [IDX_W-1:0] rd_node;
	logic [IDX_W-1:0] req_src;
	logic [IDX_W-1:0] req_dst;
	logic             req_in_range;
	logic [CNT_W-1:0] c_inc;
	logic [CNT_W-1:0] r_adv;
	logic [CNT_W-1:0] c_adv;
	logic [CW-1:0]    cnt_inc;
	logic [8:0]       cost_sat;

	// The loops run over the smaller of active_nodes and the table size.
	assign n_ext = (LW'(active_q) < LW'(NODE_COUNT_MAX)) ? LW'(active_q) : LW'(NODE_COUNT_MAX);
	assign n     = n_ext[CNT_W-1:0];

	assign rd_vld  = rd_q[ENT_W-1];
	assign rd_node = rd_q[IDX_W-1:0];

	assign req_src      = IDX_W'(req.from_node);
	assign req_dst      = IDX_W'(req.to_node);
	assign req_in_range = (32'(req.from_node) < NODE_COUNT_MAX) &&
		(32'(req.to_node) < NODE_COUNT_MAX);

	// Next pair of the resolve walk, column first.
	assign c_inc = c_q + 1'b1;
	always_comb begin
		if (c_inc >= n) begin
			c_adv = '0;
			r_adv = r_q + 1'b1;
		end else begin
			c_adv = c_inc;
			r_adv = r_q;
		end
	end

	// Hop count of the query walk and its saturated output form.
	assign cnt_inc  = cnt_q + 1'b1;
	assign cost_sat = (cnt_inc > CW'(COST_FIELD_MAX)) ? 9'(COST_FIELD_MAX) : cnt_inc[8:0];

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Sequencer.
	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		clr_op_d    = clr_op_q;
		src_d       = src_q;
		dst_d       = dst_q;
		mode_d      = mode_q;
		ret_res_d   = ret_res_q;
		i_d         = i_q;
		pend_d      = pend_q;
		pidx_d      = pidx_q;
		r_d         = r_q;
		c_d         = c_q;
		cnt_d       = cnt_q;
		res_d       = res_q;
		out_d       = out_q;
		out_valid_d = out_valid_q;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = '0;
		mem_raddr   = '0;

		// The response register empties on a transfer.
		if (out_valid_q && !rsp_stall) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				clr_d     = clr_q + 1'b1;
				if (&clr_q) begin
					state_d = clr_op_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					src_d = req_src;
					dst_d = req_dst;
					res_d = '0;
					case (req.func)
						FUNC_QUERY: begin
							if (req_in_range) begin
								mem_raddr = {req_src, req_dst};
								cnt_d     = '0;
								state_d   = S_Q_EV;
							end else begin
								state_d = S_DONE;
							end
						end
						FUNC_ADD: begin
							if (req_in_range && (req.from_node != req.to_node)) begin
								state_d = S_ADD_W;
							end else begin
								state_d = S_DONE;
							end
						end
						FUNC_REMOVE: begin
							state_d = req_in_range ? S_REM_W : S_DONE;
						end
						FUNC_RESOLVE: begin
							r_d     = '0;
							c_d     = '0;
							state_d = S_RES_RD;
						end
						FUNC_CLEAR: begin
							clr_d    = '0;
							clr_op_d = 1'b1;
							state_d  = S_CLR;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_ADD_W: begin
				// Direct link, then copy routes across it.
				mem_we    = 1'b1;
				mem_waddr = {src_q, dst_q};
				mem_wdata = {1'b1, dst_q};
				mode_d    = MODE_SPREAD;
				ret_res_d = 1'b0;
				i_d       = '0;
				pend_d    = 1'b0;
				state_d   = S_SCAN;
			end
			S_REM_W: begin
				// Cut the link, then drop row entries that point at it.
				mem_we    = 1'b1;
				mem_waddr = {src_q, dst_q};
				mode_d    = MODE_REMOVE;
				ret_res_d = 1'b0;
				i_d       = '0;
				pend_d    = 1'b0;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				// Evaluate the entry read in the previous cycle.
				if (pend_q) begin
					if (mode_q == MODE_SPREAD) begin
						if (rd_vld) begin
							mem_we    = 1'b1;
							mem_waddr = {pidx_q, dst_q};
							mem_wdata = (pidx_q == dst_q) ? '0 : {1'b1, rd_node};
						end
					end else begin
						if (rd_vld && (rd_node == dst_q)) begin
							mem_we    = 1'b1;
							mem_waddr = {src_q, pidx_q};
						end
					end
				end
				// Issue the next read, or leave once the row is done.
				if (i_q < n) begin
					mem_raddr = (mode_q == MODE_SPREAD) ? {i_q[IDX_W-1:0], src_q}
						: {src_q, i_q[IDX_W-1:0]};
					pend_d = 1'b1;
					pidx_d = i_q[IDX_W-1:0];
					i_d    = i_q + 1'b1;
				end else begin
					pend_d = 1'b0;
					if (ret_res_q) begin
						r_d     = r_adv;
						c_d     = c_adv;
						state_d = S_RES_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_RES_RD: begin
				if (r_q >= n) begin
					state_d = S_DONE;
				end else begin
					mem_raddr = {r_q[IDX_W-1:0], c_q[IDX_W-1:0]};
					state_d   = S_RES_EV;
				end
			end
			S_RES_EV: begin
				// A direct link starts a spread of its own.
				if ((r_q != c_q) && rd_vld && (rd_node == c_q[IDX_W-1:0])) begin
					src_d     = r_q[IDX_W-1:0];
					dst_d     = c_q[IDX_W-1:0];
					mode_d    = MODE_SPREAD;
					ret_res_d = 1'b1;
					i_d       = '0;
					pend_d    = 1'b0;
					state_d   = S_SCAN;
				end else begin
					r_d     = r_adv;
					c_d     = c_adv;
					state_d = S_RES_RD;
				end
			end
			S_Q_EV: begin
				// One hop of the walk per read.
				if (!rd_vld) begin
					res_d   = '0;
					state_d = S_DONE;
				end else if (cnt_inc > CW'(HOP_LIMIT)) begin
					res_d.reachable = 1'b1;
					res_d.hop_cost  = cost_sat;
					res_d.capped    = 1'b1;
					state_d         = S_DONE;
				end else if (rd_node == dst_q) begin
					res_d.reachable = 1'b1;
					res_d.hop_cost  = cost_sat;
					res_d.capped    = 1'b0;
					state_d         = S_DONE;
				end else begin
					mem_raddr = {rd_node, dst_q};
					cnt_d     = cnt_inc;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !rsp_stall) begin
					out_d       = res_q;
					out_valid_d = 1'b1;
					clr_op_d    = 1'b0;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			active_q    <= ACTIVE_NODES_RST;
			clr_q       <= '0;
			clr_op_q    <= 1'b0;
			src_q       <= '0;
			dst_q       <= '0;
			mode_q      <= MODE_SPREAD;
			ret_res_q   <= 1'b0;
			i_q         <= '0;
			pend_q      <= 1'b0;
			pidx_q      <= '0;
			r_q         <= '0;
			c_q         <= '0;
			cnt_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			clr_op_q    <= clr_op_d;
			src_q       <= src_d;
			dst_q       <= dst_d;
			mode_q      <= mode_d;
			ret_res_q   <= ret_res_d;
			i_q         <= i_d;
			pend_q      <= pend_d;
			pidx_q      <= pidx_d;
			r_q         <= r_d;
			c_q         <= c_d;
			cnt_q       <= cnt_d;
			res_q       <= res_d;
			out_q       <= out_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
		end
	end

	// Next-hop table: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem_q[mem_raddr];
	end

endmodule
